// ----- sv/pidl_pkg.sv -----
package pidl_pkg;

    // Fixed widths of the channel fields.
    localparam int POS_W      = 9;
    localparam int ELEM_OUT_W = 32;
    localparam int COUNT_W    = 9;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_POP    = 2'd1,
        KIND_READ   = 2'd2,
        KIND_WRITE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast to every cell of the chain; at most one of the strobes is high.
    typedef struct packed {
        logic             ins;
        logic             pop;
        logic             wr;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage

// ----- sv/pidl_cell.sv -----
module pidl_cell #(
    parameter int CAPACITY      = 256,
    parameter int ELEMENT_WIDTH = 32,
    parameter int INDEX         = 0
) (
    input  logic                     i_clk,
    input  pidl_pkg::t_cell_ctl      i_ctl,
    input  logic [ELEMENT_WIDTH-1:0] i_value,
    input  logic [ELEMENT_WIDTH-1:0] i_left,
    input  logic [ELEMENT_WIDTH-1:0] i_right,
    output logic [ELEMENT_WIDTH-1:0] o_data,
    output logic [ELEMENT_WIDTH-1:0] o_tap
);

    localparam int IDX_W = $clog2(CAPACITY) + 1;
    localparam int CMP_W = (IDX_W > pidl_pkg::POS_W) ? IDX_W : pidl_pkg::POS_W;
    localparam logic [CMP_W-1:0] L_INDEX = CMP_W'(INDEX);

    logic [ELEMENT_WIDTH-1:0] r_data;
    logic [ELEMENT_WIDTH-1:0] n_data;
    logic [CMP_W-1:0]         w_pos;
    logic                     w_hit;
    logic                     w_above;

    assign w_pos   = CMP_W'(i_ctl.pos);
    assign w_hit   = (w_pos == L_INDEX);
    assign w_above = (L_INDEX > w_pos);

    // Insert pulls from the left neighbour, pop from the right one.
    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (w_hit) begin
                n_data = i_value;
            end else if (w_above) begin
                n_data = i_left;
            end
        end
        if (i_ctl.pop && (w_hit || w_above)) begin
            n_data = i_right;
        end
        if (i_ctl.wr && w_hit) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = w_hit ? r_data : '0;

endmodule

// ----- sv/positional_insert_delete_list_top.sv -----
// Channel | Direction | Handshake                  | Fields
// --------+-----------+----------------------------+--------------------------------
// in      | in        | i_in_valid / o_in_stall    | i_kind, i_position, i_value
// out     | out       | o_out_valid / i_out_stall  | o_element, o_count, o_status
//
// The row of cells shifts all stored elements in parallel, so one beat can be
// accepted in each cycle unless o_in_stall holds the input side.
// The result of a beat is registered and appears on the cycle after it is accepted.
// Reset (i_rst_n low at a clock edge) empties the list; stored words are not cleared.
// The input side is stalled while reset is held, so no beat is taken and lost.
// A stalled result holds the input side only if the output register is still full.

module positional_insert_delete_list_top #(
    parameter int CAPACITY      = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_kind,
    input  logic [pidl_pkg::POS_W-1:0]      i_position,
    input  logic [31:0]                     i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pidl_pkg::ELEM_OUT_W-1:0] o_element,
    output logic [pidl_pkg::COUNT_W-1:0]    o_count,
    output logic [1:0]                      o_status
);

    // The count must be able to hold CAPACITY itself.
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > pidl_pkg::POS_W) ? CNT_W : pidl_pkg::POS_W;
    localparam int TREE_L  = $clog2(CAPACITY);
    localparam int TREE_N  = 2 ** TREE_L;

    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               n_count;
    logic                           r_out_valid;
    logic [pidl_pkg::ELEM_OUT_W-1:0] r_element;
    logic [pidl_pkg::COUNT_W-1:0]   r_count_out;
    pidl_pkg::t_status              r_status;

    logic                           w_accept;
    pidl_pkg::t_kind                w_kind;
    pidl_pkg::t_status              w_status;
    logic                           w_ok;
    logic [CMP_W-1:0]               w_pos;
    logic [CMP_W-1:0]               w_cnt;
    logic [ELEMENT_WIDTH-1:0]       w_value;
    logic [pidl_pkg::ELEM_OUT_W-1:0] w_element;
    pidl_pkg::t_cell_ctl            w_ctl;

    logic [ELEMENT_WIDTH-1:0]       w_data [CAPACITY];
    logic [ELEMENT_WIDTH-1:0]       w_node [2*TREE_N-1];

    // The output register parts the two sides; a free or draining register
    // lets the next beat in.
    assign o_in_stall = !i_rst_n || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_kind  = pidl_pkg::t_kind'(i_kind);
    assign w_pos   = CMP_W'(i_position);
    assign w_cnt   = CMP_W'(r_count);
    assign w_value = ELEMENT_WIDTH'(i_value);

    // Range is checked before fullness on insert, as the list requires.
    always_comb begin
        w_status = pidl_pkg::ST_OK;
        if (w_kind == pidl_pkg::KIND_INSERT) begin
            if (w_pos > w_cnt) begin
                w_status = pidl_pkg::ST_RANGE;
            end else if (r_count == CNT_W'(CAPACITY)) begin
                w_status = pidl_pkg::ST_FULL;
            end
        end else if (w_pos >= w_cnt) begin
            w_status = pidl_pkg::ST_RANGE;
        end
    end

    assign w_ok = (w_status == pidl_pkg::ST_OK);

    // Only successful operations that change the store drive the cells.
    always_comb begin
        w_ctl.ins = w_accept && w_ok && (w_kind == pidl_pkg::KIND_INSERT);
        w_ctl.pop = w_accept && w_ok && (w_kind == pidl_pkg::KIND_POP);
        w_ctl.wr  = w_accept && w_ok && (w_kind == pidl_pkg::KIND_WRITE);
        w_ctl.pos = i_position;
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // The row of cells: cell g holds list position g.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEMENT_WIDTH-1:0] w_left;
        logic [ELEMENT_WIDTH-1:0] w_right;
        logic [ELEMENT_WIDTH-1:0] w_tap;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        pidl_cell #(
            .CAPACITY      (CAPACITY),
            .ELEMENT_WIDTH (ELEMENT_WIDTH),
            .INDEX         (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_tap   (w_tap)
        );

        assign w_node[TREE_N-1+g] = w_tap;
    end

    // Padding leaves of the OR tree when the capacity is not a power of two.
    for (genvar p = CAPACITY; p < TREE_N; p++) begin : g_pad
        assign w_node[TREE_N-1+p] = '0;
    end

    // At most one cell taps out its word, so an OR tree selects it.
    for (genvar t = 0; t < TREE_N - 1; t++) begin : g_tree
        assign w_node[t] = w_node[2*t+1] | w_node[2*t+2];
    end

    always_comb begin
        w_element = '0;
        if (w_ok && (w_kind inside {pidl_pkg::KIND_POP, pidl_pkg::KIND_READ})) begin
            w_element = pidl_pkg::ELEM_OUT_W'(w_node[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_element   <= w_element;
            r_count_out <= pidl_pkg::COUNT_W'(n_count);
            r_status    <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_element   = r_element;
    assign o_count     = r_count_out;
    assign o_status    = r_status;

    // The list never grows past its capacity.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list count exceeds capacity");

    // A successful insert grows the list by exactly one element.
    a_insert_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list by one");

    // A full status is only ever reported with the list at capacity.
    a_full_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_status == pidl_pkg::ST_FULL)) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    // An error result carries a zero element.
    a_error_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != pidl_pkg::ST_OK)) |-> (r_element == '0))
        else $error("error result with non-zero element");

endmodule
